FILE: hw/rtl/sge_pkg.sv
// Shared types, constants, sine table and microcode for the stereo gain envelope.
`default_nettype none

package sge_pkg;

  // Sine table geometry
  localparam int unsigned SINE_ENTRIES = 256;
  localparam int unsigned SINE_AW      = $clog2(SINE_ENTRIES);

  // Register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_GAIN       = 3'd1,
    REG_FIN_FRAMES = 3'd2,
    REG_FIN_RECIP  = 3'd3,
    REG_FOUT_FRAMES = 3'd4,
    REG_FOUT_RECIP = 3'd5,
    REG_TOTAL      = 3'd6,
    REG_TREM_STEP  = 3'd7
  } cfg_reg_t;

  // Gain modes
  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_FIN   = 2'd1;
  localparam logic [1:0] MODE_FADE  = 2'd2;
  localparam logic [1:0] MODE_TREM  = 2'd3;

  // Reset values of the registers
  localparam logic [15:0] GAIN_RST       = 16'd4096;
  localparam logic [31:0] FIN_FRAMES_RST = 32'd22050;
  localparam logic [15:0] FIN_RECIP_RST  = 16'd2;
  localparam logic [31:0] FOUT_FRAMES_RST = 32'd176400;
  localparam logic [15:0] FOUT_RECIP_RST = 16'd0;
  localparam logic [31:0] TOTAL_RST      = 32'd0;
  localparam logic [31:0] TREM_STEP_RST  = 32'd389566;

  // Arithmetic constants
  localparam logic [16:0] RAMP_ONE   = 17'd65536;
  localparam logic [15:0] GAIN_UNITY = 16'd4096;
  localparam logic [31:0] TREM_DEPTH = 32'd819;

  // Payload types
  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               clipped;
  } out_item_t;

  // Sine ROM: bit 15 is the negative half, bits 14:0 the magnitude
  typedef logic [15:0] sine_rom_t [SINE_ENTRIES];

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t   rom;
    logic [63:0] u;
    logic [63:0] h;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] y;
    logic        neg;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      u   = ((64'(k) * 64'd65536) / 64'(SINE_ENTRIES)) & 64'hFFFF;
      neg = (u >= 64'd32768);
      h   = neg ? u - 64'd32768 : u;
      if (h > 64'd16384) begin
        h = 64'd32768 - h;
      end
      x  = h * 64'd2;
      x2 = (x * x) >> 15;
      y  = (64'd2458 * x2) >> 15;
      y  = 64'd21162 - y;
      y  = (y * x2) >> 15;
      y  = 64'd51472 - y;
      y  = (y * x) >> 15;
      if (y > 64'd32767) begin
        y = 64'd32767;
      end
      rom[k] = {neg, y[14:0]};
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  // Microcode fields
  localparam int unsigned PC_W = 5;

  typedef enum logic [3:0] {
    COND_NEXT       = 4'd0,
    COND_ALWAYS     = 4'd1,
    COND_NOT_BUSY   = 4'd2,
    COND_MODE_TREM  = 4'd3,
    COND_MODE_CONST = 4'd4,
    COND_FIN_ACTIVE = 4'd5,
    COND_MODE_NOT2  = 4'd6,
    COND_PAST_END   = 4'd7,
    COND_FOUT_IDLE  = 4'd8,
    COND_OUT_FULL   = 4'd9
  } cond_t;

  typedef enum logic [2:0] {
    ASEL_COUNT = 3'd0,
    ASEL_REM   = 3'd1,
    ASEL_GAIN  = 3'd2,
    ASEL_DEPTH = 3'd3,
    ASEL_LMAG  = 3'd4,
    ASEL_RMAG  = 3'd5
  } a_sel_t;

  typedef enum logic [2:0] {
    BSEL_FIN_RECIP  = 3'd0,
    BSEL_FOUT_RECIP = 3'd1,
    BSEL_RAMP       = 3'd2,
    BSEL_SINE       = 3'd3,
    BSEL_GAIN       = 3'd4
  } b_sel_t;

  typedef enum logic [3:0] {
    DST_NONE   = 4'd0,
    DST_RCLAMP = 4'd1,
    DST_RUNITY = 4'd2,
    DST_RZERO  = 4'd3,
    DST_GAIN   = 4'd4,
    DST_TGAIN  = 4'd5,
    DST_RES_L  = 4'd6,
    DST_RES_R  = 4'd7,
    DST_EMIT   = 4'd8
  } dest_t;

  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            mul_en;
    a_sel_t          asel;
    b_sel_t          bsel;
    dest_t           dest;
  } ctrl_word_t;

  typedef struct packed {
    logic busy;
    logic mode_trem;
    logic mode_const;
    logic fin_active;
    logic mode_not2;
    logic past_end;
    logic fout_idle;
    logic out_full;
  } seq_flags_t;

  // Program addresses
  localparam logic [PC_W-1:0] STEP_WAIT   = 5'd0;
  localparam logic [PC_W-1:0] STEP_FOUT   = 5'd7;
  localparam logic [PC_W-1:0] STEP_FIN    = 5'd8;
  localparam logic [PC_W-1:0] STEP_RCLAMP = 5'd9;
  localparam logic [PC_W-1:0] STEP_UNITY  = 5'd10;
  localparam logic [PC_W-1:0] STEP_ZERO   = 5'd11;
  localparam logic [PC_W-1:0] STEP_GAIN   = 5'd12;
  localparam logic [PC_W-1:0] STEP_TREM   = 5'd14;
  localparam logic [PC_W-1:0] STEP_SCALE  = 5'd16;
  localparam logic [PC_W-1:0] STEP_EMIT   = 5'd20;

  function automatic ctrl_word_t ucode(logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{cond: COND_NEXT, target: STEP_WAIT, mul_en: 1'b0,
          asel: ASEL_COUNT, bsel: BSEL_FIN_RECIP, dest: DST_NONE};
    case (pc)
      5'd0:  begin w.cond = COND_NOT_BUSY;   w.target = STEP_WAIT;  end
      5'd1:  begin w.cond = COND_MODE_TREM;  w.target = STEP_TREM;  end
      5'd2:  begin w.cond = COND_MODE_CONST; w.target = STEP_UNITY; end
      5'd3:  begin w.cond = COND_FIN_ACTIVE; w.target = STEP_FIN;   end
      5'd4:  begin w.cond = COND_MODE_NOT2;  w.target = STEP_UNITY; end
      5'd5:  begin w.cond = COND_PAST_END;   w.target = STEP_ZERO;  end
      5'd6:  begin w.cond = COND_FOUT_IDLE;  w.target = STEP_UNITY; end
      5'd7:  begin
        w.cond = COND_ALWAYS; w.target = STEP_RCLAMP;
        w.mul_en = 1'b1; w.asel = ASEL_REM; w.bsel = BSEL_FOUT_RECIP;
      end
      5'd8:  begin
        w.mul_en = 1'b1; w.asel = ASEL_COUNT; w.bsel = BSEL_FIN_RECIP;
      end
      5'd9:  begin w.cond = COND_ALWAYS; w.target = STEP_GAIN; w.dest = DST_RCLAMP; end
      5'd10: begin w.cond = COND_ALWAYS; w.target = STEP_GAIN; w.dest = DST_RUNITY; end
      5'd11: begin w.dest = DST_RZERO; end
      5'd12: begin w.mul_en = 1'b1; w.asel = ASEL_GAIN; w.bsel = BSEL_RAMP; end
      5'd13: begin w.cond = COND_ALWAYS; w.target = STEP_SCALE; w.dest = DST_GAIN; end
      5'd14: begin w.mul_en = 1'b1; w.asel = ASEL_DEPTH; w.bsel = BSEL_SINE; end
      5'd15: begin w.dest = DST_TGAIN; end
      5'd16: begin w.mul_en = 1'b1; w.asel = ASEL_LMAG; w.bsel = BSEL_GAIN; end
      5'd17: begin w.dest = DST_RES_L; end
      5'd18: begin w.mul_en = 1'b1; w.asel = ASEL_RMAG; w.bsel = BSEL_GAIN; end
      5'd19: begin w.dest = DST_RES_R; end
      5'd20: begin w.cond = COND_OUT_FULL; w.target = STEP_EMIT; w.dest = DST_EMIT; end
      5'd21: begin w.cond = COND_ALWAYS; w.target = STEP_WAIT; end
      default: begin w.cond = COND_ALWAYS; w.target = STEP_WAIT; end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sge_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module sge_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sge_pkg::seq_flags_t flags,
  output sge_pkg::ctrl_word_t      ctrl
);

  logic [sge_pkg::PC_W-1:0] pc_r;
  logic [sge_pkg::PC_W-1:0] pc_nxt;
  logic                     take;

  assign ctrl = sge_pkg::ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      sge_pkg::COND_NEXT:       take = 1'b0;
      sge_pkg::COND_ALWAYS:     take = 1'b1;
      sge_pkg::COND_NOT_BUSY:   take = !flags.busy;
      sge_pkg::COND_MODE_TREM:  take = flags.mode_trem;
      sge_pkg::COND_MODE_CONST: take = flags.mode_const;
      sge_pkg::COND_FIN_ACTIVE: take = flags.fin_active;
      sge_pkg::COND_MODE_NOT2:  take = flags.mode_not2;
      sge_pkg::COND_PAST_END:   take = flags.past_end;
      sge_pkg::COND_FOUT_IDLE:  take = flags.fout_idle;
      sge_pkg::COND_OUT_FULL:   take = flags.out_full;
      default:                  take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= sge_pkg::STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stereo_gain_envelope.sv
// Top level of the stereo gain envelope: registers, shared-multiplier datapath, handshakes.
`default_nettype none

// Channel   Handshake                 Payload                       Direction
// in_       in_valid / in_ready       in_data  (left, right, restart)   into block
// out_      out_valid / out_ready     out_data (left, right, clipped)   out of block
// cfg_      cfg_we                    cfg_index, cfg_data              into block
//
// One frame at a time: each frame goes from its transfer to its result along the
// microcode path through the one shared 32x17 multiplier.
// A new frame is taken as soon as the previous result has been placed in the
// output register, so a waiting result does not hold back the next transfer.
// Synchronous active-low reset restores the register defaults and clears the
// frame counter and tremolo phase; a stalled output holds the program at its
// emit step until the result register is free.

module stereo_gain_envelope (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire sge_pkg::in_item_t                    in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output sge_pkg::out_item_t                        out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [sge_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [31:0]                          cfg_data
);

  // Configuration registers
  logic [1:0]  mode_r;
  logic [15:0] gain_r;
  logic [31:0] fin_frames_r;
  logic [15:0] fin_recip_r;
  logic [31:0] fout_frames_r;
  logic [15:0] fout_recip_r;
  logic [31:0] total_r;
  logic [31:0] trem_step_r;

  // Running state
  logic [31:0] count_r, count_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic        busy_r, busy_nxt;

  // Datapath registers
  logic [15:0] lmag_r, rmag_r;
  logic        lneg_r, rneg_r;
  logic [48:0] prod_r;
  logic [16:0] ramp_r;
  logic [15:0] g_r;
  logic [15:0] res_l_r, res_r_r;
  logic        clip_r;
  logic        out_valid_r;
  sge_pkg::out_item_t out_data_r;

  sge_pkg::ctrl_word_t ctrl;
  sge_pkg::seq_flags_t flags;

  logic        in_xfer;
  logic        emit;
  logic [31:0] rem;
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [15:0] sine_word;
  logic [9:0]  trem_d;
  logic [18:0] q_now;
  logic [15:0] sat_val;
  logic        sat_clip;
  logic        cur_neg;

  assign in_ready  = !busy_r;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer
  assign rem = total_r - count_r;

  always_comb begin
    flags.busy       = busy_r;
    flags.mode_trem  = (mode_r == sge_pkg::MODE_TREM);
    flags.mode_const = (mode_r == sge_pkg::MODE_CONST);
    flags.fin_active = (count_r < fin_frames_r);
    flags.mode_not2  = (mode_r != sge_pkg::MODE_FADE);
    flags.past_end   = (count_r >= total_r);
    flags.fout_idle  = !(rem < fout_frames_r);
    flags.out_full   = out_valid_r && !out_ready;
  end

  sge_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Tremolo table lookup from the top bits of the phase
  assign sine_word = sge_pkg::SINE_ROM[phase_r[31 -: sge_pkg::SINE_AW]];
  assign trem_d    = prod_r[24:15];

  // Multiplier operand selection
  always_comb begin
    case (ctrl.asel)
      sge_pkg::ASEL_COUNT: mul_a = count_r;
      sge_pkg::ASEL_REM:   mul_a = rem;
      sge_pkg::ASEL_GAIN:  mul_a = {16'd0, gain_r};
      sge_pkg::ASEL_DEPTH: mul_a = sge_pkg::TREM_DEPTH;
      sge_pkg::ASEL_LMAG:  mul_a = {16'd0, lmag_r};
      sge_pkg::ASEL_RMAG:  mul_a = {16'd0, rmag_r};
      default:             mul_a = '0;
    endcase
    case (ctrl.bsel)
      sge_pkg::BSEL_FIN_RECIP:  mul_b = {1'b0, fin_recip_r};
      sge_pkg::BSEL_FOUT_RECIP: mul_b = {1'b0, fout_recip_r};
      sge_pkg::BSEL_RAMP:       mul_b = ramp_r;
      sge_pkg::BSEL_SINE:       mul_b = {2'd0, sine_word[14:0]};
      sge_pkg::BSEL_GAIN:       mul_b = {1'b0, g_r};
      default:                  mul_b = '0;
    endcase
  end

  // Saturate the scaled magnitude of whichever channel this step writes
  assign cur_neg = (ctrl.dest == sge_pkg::DST_RES_R) ? rneg_r : lneg_r;
  assign q_now   = prod_r[30:12];

  always_comb begin
    if (cur_neg) begin
      sat_clip = (q_now > 19'd32768);
      sat_val  = sat_clip ? 16'h8000 : 16'(-q_now[15:0]);
    end else begin
      sat_clip = (q_now > 19'd32767);
      sat_val  = sat_clip ? 16'h7FFF : q_now[15:0];
    end
  end

  assign emit = (ctrl.dest == sge_pkg::DST_EMIT) && !flags.out_full;

  // Frame counter and phase: clear on a restart transfer, advance on emit; busy flag: set on a transfer, clear on emit
  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
      if (in_data.restart) begin
        count_nxt = '0;
        phase_nxt = '0;
      end
    end else if (emit) begin
      busy_nxt  = 1'b0;
      count_nxt = (count_r == 32'hFFFF_FFFF) ? count_r : count_r + 32'd1;
      phase_nxt = phase_r + trem_step_r;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= sge_pkg::MODE_CONST;
      gain_r        <= sge_pkg::GAIN_RST;
      fin_frames_r  <= sge_pkg::FIN_FRAMES_RST;
      fin_recip_r   <= sge_pkg::FIN_RECIP_RST;
      fout_frames_r <= sge_pkg::FOUT_FRAMES_RST;
      fout_recip_r  <= sge_pkg::FOUT_RECIP_RST;
      total_r       <= sge_pkg::TOTAL_RST;
      trem_step_r   <= sge_pkg::TREM_STEP_RST;
      count_r       <= '0;
      phase_r       <= '0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      busy_r  <= busy_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (sge_pkg::cfg_reg_t'(cfg_index))
          sge_pkg::REG_MODE:        mode_r        <= cfg_data[1:0];
          sge_pkg::REG_GAIN:        gain_r        <= cfg_data[15:0];
          sge_pkg::REG_FIN_FRAMES:  fin_frames_r  <= cfg_data;
          sge_pkg::REG_FIN_RECIP:   fin_recip_r   <= cfg_data[15:0];
          sge_pkg::REG_FOUT_FRAMES: fout_frames_r <= cfg_data;
          sge_pkg::REG_FOUT_RECIP:  fout_recip_r  <= cfg_data[15:0];
          sge_pkg::REG_TOTAL:       total_r       <= cfg_data;
          sge_pkg::REG_TREM_STEP:   trem_step_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath: sample capture, product register and step results
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lneg_r <= in_data.left_in[15];
      rneg_r <= in_data.right_in[15];
      lmag_r <= in_data.left_in[15] ? 16'(-in_data.left_in) : in_data.left_in;
      rmag_r <= in_data.right_in[15] ? 16'(-in_data.right_in) : in_data.right_in;
    end
    if (ctrl.mul_en) begin
      prod_r <= {17'd0, mul_a} * {32'd0, mul_b};
    end
    case (ctrl.dest)
      sge_pkg::DST_RCLAMP: ramp_r <= (prod_r > 49'(sge_pkg::RAMP_ONE)) ?
                                     sge_pkg::RAMP_ONE : prod_r[16:0];
      sge_pkg::DST_RUNITY: ramp_r <= sge_pkg::RAMP_ONE;
      sge_pkg::DST_RZERO:  ramp_r <= '0;
      sge_pkg::DST_GAIN:   g_r    <= prod_r[31:16];
      sge_pkg::DST_TGAIN:  g_r    <= sine_word[15] ?
                                     sge_pkg::GAIN_UNITY - 16'(trem_d) :
                                     sge_pkg::GAIN_UNITY + 16'(trem_d);
      sge_pkg::DST_RES_L: begin
        res_l_r <= sat_val;
        clip_r  <= sat_clip;
      end
      sge_pkg::DST_RES_R: begin
        res_r_r <= sat_val;
        clip_r  <= clip_r | sat_clip;
      end
      sge_pkg::DST_EMIT: begin
        if (emit) begin
          out_data_r.left_out  <= res_l_r;
          out_data_r.right_out <= res_r_r;
          out_data_r.clipped   <= clip_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/tb_stereo_gain_envelope.sv
// Self-checking testbench for stereo_gain_envelope: random and directed frames against a predictor.
module tb_stereo_gain_envelope;
  timeunit 1ns;
  timeprecision 1ps;

  import sge_pkg::*;

  // Fixed-point constants of the gain path
  localparam logic [16:0] RAMP_FULL     = 17'h10000;  // Q1.16 unity ramp
  localparam int unsigned Q12_ONE       = 4096;       // Q4.12 unity gain
  localparam int unsigned TREMOLO_SWING = 819;        // 0.2 in Q12
  localparam int unsigned RANDOM_FRAMES = 400;

  // Receiver stall styles
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PERIODIC,
    RDY_HOLD
  } ready_style_t;

  // Clock, reset and block ports; every input starts at a known value
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  // Frames waiting for the driver, and scaled frames waiting for the monitor
  in_item_t  frames_to_send[$];
  out_item_t due_frames[$];

  // Shadow copy of the configuration registers
  logic [1:0]  m_mode;
  logic [15:0] m_gain;
  logic [31:0] m_fin_frames;
  logic [15:0] m_fin_recip;
  logic [31:0] m_fout_frames;
  logic [15:0] m_fout_recip;
  logic [31:0] m_total;
  logic [31:0] m_step;

  // Shadow copy of the envelope state
  logic [31:0] frame_ctr;
  logic [31:0] phase_acc;

  // Driver, receiver and bookkeeping
  bit           in_taken = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;
  ready_style_t ready_style = RDY_ALWAYS;
  int           ready_left = 0;
  int           errors = 0;
  int           settings = 0;
  int           mode_frames[4] = '{0, 0, 0, 0};
  int           clipped_frames = 0;
  out_item_t    want;

  stereo_gain_envelope dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sine table entry k: magnitude in Q15 and the sign of the half cycle.
  // Fold the fraction of a cycle into the first quadrant, then evaluate the
  // odd polynomial in Q15 with truncation at every product.
  function automatic int unsigned sine_q15(input logic [31:0] k, output bit neg);
    logic [63:0] u;
    logic [63:0] h;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] y;
    u   = ((64'(k) * 65536) / SINE_ENTRIES) & 64'hFFFF;
    neg = (u >= 64'd32768);
    h   = neg ? u - 64'd32768 : u;
    if (h > 64'd16384) begin
      h = 64'd32768 - h;
    end
    x  = h * 2;
    x2 = (x * x) >> 15;
    y  = (64'd2458 * x2) >> 15;
    y  = ((64'd21162 - y) * x2) >> 15;
    y  = ((64'd51472 - y) * x) >> 15;
    return (y > 64'd32767) ? 32767 : int'(y[31:0]);
  endfunction

  // Linear ramp n * step in Q1.16, clamped at unity
  function automatic logic [16:0] ramp_step(logic [31:0] n, logic [15:0] step);
    logic [63:0] p;
    p = n * step;
    return (p > 64'(RAMP_FULL)) ? RAMP_FULL : p[16:0];
  endfunction

  // Scale one sample by a Q4.12 gain, truncating the magnitude, then saturate
  function automatic logic [15:0] scale_sample(logic [15:0] v, int unsigned g, inout bit clip);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[15] ? 64'h10000 - v : 64'(v);
    q   = (mag * g) >> 12;
    if (v[15]) begin
      if (q > 64'd32768) begin
        q    = 64'd32768;
        clip = 1'b1;
      end
      q = 64'h10000 - q;
    end else if (q > 64'd32767) begin
      q    = 64'd32767;
      clip = 1'b1;
    end
    return q[15:0];
  endfunction

  // Work out the scaled frame for one accepted transfer and advance the
  // shadow frame counter and tremolo phase.
  function automatic out_item_t predict_frame(in_item_t f);
    out_item_t   o;
    logic [63:0] w;
    logic [16:0] r;
    logic [31:0] rem;
    int unsigned g;
    int unsigned s;
    int unsigned d;
    bit          neg;
    bit          clip;
    if (f.restart) begin
      frame_ctr = '0;
      phase_acc = '0;
    end
    clip = 1'b0;
    if (m_mode == MODE_TREM) begin
      // tremolo ignores the user gain
      w = phase_acc;
      w = (w * SINE_ENTRIES) >> 32;
      s = sine_q15(w[31:0], neg);
      d = (TREMOLO_SWING * s) >> 15;
      g = neg ? Q12_ONE - d : Q12_ONE + d;
    end else begin
      r = RAMP_FULL;
      if (m_mode == MODE_FIN || m_mode == MODE_FADE) begin
        // fade-in wins over fade-out; a zero length never matches
        if (frame_ctr < m_fin_frames) begin
          r = ramp_step(frame_ctr, m_fin_recip);
        end else if (m_mode == MODE_FADE) begin
          if (frame_ctr >= m_total) begin
            r = '0;
          end else begin
            rem = m_total - frame_ctr;
            if (rem < m_fout_frames) begin
              r = ramp_step(rem, m_fout_recip);
            end
          end
        end
      end
      w = m_gain * r;
      g = w[47:16];
    end
    o.left_out  = scale_sample(f.left_in, g, clip);
    o.right_out = scale_sample(f.right_in, g, clip);
    o.clipped   = clip;
    mode_frames[m_mode]++;
    if (clip) begin
      clipped_frames++;
    end
    if (frame_ctr != 32'hFFFF_FFFF) begin
      frame_ctr++;
    end
    phase_acc += m_step;
    return o;
  endfunction

  function automatic void queue_frame(logic [15:0] l, logic [15:0] r, logic restart);
    frames_to_send.push_back('{left_in: l, right_in: r, restart: restart});
  endfunction

  // Full-range random samples, with the extremes and small values of both signs
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(0, 255));
      5: return 16'h0000 - 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Frame lengths: zero, the largest, short ramps, or anything
  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Q0.16 ramp steps: zero, the largest, or anything
  function automatic logic [15:0] pick_recip();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1024, 24000));
    endcase
  endfunction

  // Wait at rising edges until every frame has been transferred and every
  // scaled frame has come back; the block is then idle.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (frames_to_send.size() != 0 || in_valid || due_frames.size() != 0);
  endtask

  // Write one register and mirror it into the shadow copy
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MODE:        m_mode        = val[1:0];
      REG_GAIN:        m_gain        = val[15:0];
      REG_FIN_FRAMES:  m_fin_frames  = val;
      REG_FIN_RECIP:   m_fin_recip   = val[15:0];
      REG_FOUT_FRAMES: m_fout_frames = val;
      REG_FOUT_RECIP:  m_fout_recip  = val[15:0];
      REG_TOTAL:       m_total       = val;
      REG_TREM_STEP:   m_step        = val;
      default: ;
    endcase
  endtask

  // Drain the block, then load a complete setting. The upper bits of the
  // narrow registers carry random junk, which the block must drop.
  task automatic load_setting(logic [1:0] mode, logic [15:0] gain,
                              logic [31:0] fin, logic [15:0] fin_r,
                              logic [31:0] fout, logic [15:0] fout_r,
                              logic [31:0] total, logic [31:0] step);
    wait_drained();
    write_reg(REG_MODE,        {30'($urandom), mode});
    write_reg(REG_GAIN,        {16'($urandom), gain});
    write_reg(REG_FIN_FRAMES,  fin);
    write_reg(REG_FIN_RECIP,   {16'($urandom), fin_r});
    write_reg(REG_FOUT_FRAMES, fout);
    write_reg(REG_FOUT_RECIP,  {16'($urandom), fout_r});
    write_reg(REG_TOTAL,       total);
    write_reg(REG_TREM_STEP,   step);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Driver: change inputs at the falling edge. Hold valid and payload until
  // the transfer, then advance to the next frame or drop valid for a gap.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (frames_to_send.size() != 0) begin
        in_data  <= frames_to_send.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          // end of burst: pick the next burst and the gap in front of it
          burst_left = $urandom_range(0, 11);
          case ($urandom_range(0, 5))
            0, 1, 2: gap_left = 0;
            3, 4:    gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(10, 40);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input transfer: predict the scaled frame as the block takes it
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      due_frames.push_back(predict_frame(in_data));
      in_taken = 1'b1;
    end
  end

  // Receiver: stall in styles of random length, from never to long holds
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 3));
      ready_left  = $urandom_range(8, 80);
    end else begin
      ready_left--;
    end
    case (ready_style)
      RDY_ALWAYS:   out_ready <= 1'b1;
      RDY_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
      RDY_PERIODIC: out_ready <= (ready_left % 5 == 0);
      default:      out_ready <= (ready_left < 4);
    endcase
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_frames.size() == 0) begin
        $display("%0t: result with no frame outstanding: left %0d right %0d clipped %0b",
                 $time, out_data.left_out, out_data.right_out, out_data.clipped);
        errors++;
      end else begin
        want = due_frames.pop_front();
        if (out_data.left_out !== want.left_out) begin
          $display("%0t: left_out expected %0d, got %0d",
                   $time, want.left_out, out_data.left_out);
          errors++;
        end
        if (out_data.right_out !== want.right_out) begin
          $display("%0t: right_out expected %0d, got %0d",
                   $time, want.right_out, out_data.right_out);
          errors++;
        end
        if (out_data.clipped !== want.clipped) begin
          $display("%0t: clipped expected %0b, got %0b",
                   $time, want.clipped, out_data.clipped);
          errors++;
        end
      end
    end
  end

  // Stimulus: directed settings first, then random settings and frames
  initial begin
    logic [1:0]  mode;
    logic [15:0] gain;
    logic [31:0] total;
    logic [31:0] step;
    int          count;
    int          random_sent;

    // shadow state starts at the reset values of the block
    m_mode        = MODE_CONST;
    m_gain        = GAIN_RST;
    m_fin_frames  = FIN_FRAMES_RST;
    m_fin_recip   = FIN_RECIP_RST;
    m_fout_frames = FOUT_FRAMES_RST;
    m_fout_recip  = FOUT_RECIP_RST;
    m_total       = TOTAL_RST;
    m_step        = TREM_STEP_RST;
    frame_ctr     = '0;
    phase_acc     = '0;
    random_sent   = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting at unity: sample extremes pass through unchanged
    queue_frame(16'h7FFF, 16'h8000, 1'b1);
    queue_frame(16'h8000, 16'h7FFF, 1'b0);
    queue_frame(16'h0000, 16'hFFFF, 1'b0);
    queue_frame(16'h0001, 16'h0000, 1'b0);

    // Largest constant gain: full-scale samples saturate, small ones do not
    load_setting(MODE_CONST, 16'hFFFF, FIN_FRAMES_RST, FIN_RECIP_RST,
                 FOUT_FRAMES_RST, FOUT_RECIP_RST, TOTAL_RST, TREM_STEP_RST);
    queue_frame(16'h7FFF, 16'h8000, 1'b0);
    queue_frame(16'h0008, 16'hFFF8, 1'b0);

    // Short fade-in whose last step overshoots unity and clamps
    load_setting(MODE_FIN, 16'd4096, 32'd4, 16'd30000, 32'd0, 16'd0, 32'd0, 32'd0);
    for (int i = 0; i < 5; i++) begin
      queue_frame(16'h7FFF, 16'h8000, i == 0);
    end

    // Fade-in, flat, fade-out, then past the end of the pass
    load_setting(MODE_FADE, 16'd4096, 32'd2, 16'd32768, 32'd3, 16'd16384, 32'd6, 32'd0);
    for (int i = 0; i < 8; i++) begin
      queue_frame(16'h4000, 16'hC000, i == 0);
    end

    // Both fades of zero length never engage
    load_setting(MODE_FADE, 16'd8192, 32'd0, 16'hFFFF, 32'd0, 16'hFFFF, 32'd1, 32'd0);
    queue_frame(16'h1234, 16'hEDCC, 1'b1);
    queue_frame(16'h1234, 16'hEDCC, 1'b0);

    // Tremolo in quarter cycles: zero, positive peak, zero, negative peak
    load_setting(MODE_TREM, 16'd100, 32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 32'h4000_0000);
    for (int i = 0; i < 4; i++) begin
      queue_frame(16'h7FFF, 16'h8000, i == 0);
    end

    // Random settings, each a pass from a restart with occasional restarts inside
    while (random_sent < RANDOM_FRAMES) begin
      mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0:       gain = 16'd0;
        1:       gain = 16'hFFFF;
        2:       gain = 16'd4096;
        3:       gain = 16'($urandom);
        default: gain = 16'($urandom_range(2048, 8192));
      endcase
      case ($urandom_range(0, 5))
        0:       total = 32'd0;
        1:       total = 32'hFFFF_FFFF;
        default: total = $urandom_range(1, 80);
      endcase
      case ($urandom_range(0, 4))
        0:       step = 32'd0;
        1:       step = 32'hFFFF_FFFF;
        2:       step = 32'($urandom_range(1, 255)) << 24;
        default: step = $urandom;
      endcase
      load_setting(mode, gain, pick_length(), pick_recip(),
                   pick_length(), pick_recip(), total, step);
      count = $urandom_range(10, 50);
      for (int i = 0; i < count; i++) begin
        queue_frame(rand_sample(), rand_sample(), i == 0 || $urandom_range(0, 31) == 0);
      end
      random_sent += count;
    end

    // Drain, then allow the block's worst-case latency before the verdict
    wait_drained();
    repeat (40) @(posedge clk);
    $display("Covered %0d settings: %0d constant, %0d fade-in, %0d fade-out, %0d tremolo frames",
             settings + 1, mode_frames[MODE_CONST], mode_frames[MODE_FIN],
             mode_frames[MODE_FADE], mode_frames[MODE_TREM]);
    $display("%0d frames saturated, %0d mismatches", clipped_frames, errors);
    if (errors == 0 && due_frames.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
